@@ hdl/csvft_pkg.sv @@
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared types and constants for the csv field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvft_pkg;

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    // configuration register reset values
    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHAR = 2'd1;

    // event kinds
    localparam logic [1:0] EV_CONTENT = 2'd0;
    localparam logic [1:0] EV_FIELD   = 2'd1;
    localparam logic [1:0] EV_ROW     = 2'd2;

    // most events one byte can cause
    localparam int unsigned MAX_EVTS = 3;

    // one output event
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } csv_evt_t;

    // all events caused by one byte, slot 0 first
    typedef struct packed {
        csv_evt_t [MAX_EVTS-1:0] evts;
        logic [1:0]              cnt;
    } csv_bundle_t;

    // head of the event queue as seen by the back end
    typedef struct packed {
        logic        empty;
        csv_bundle_t head;
    } csv_qhead_t;

endpackage : csvft_pkg

`default_nettype wire

@@ hdl/csv_field_tokenizer.sv @@
// Path: a byte accepted enters the event queue, and its first event is then
// loaded from the queue head into the output register when that is free.
// Throughput: one byte per cycle while the output keeps up; the single output
// register drains one event per cycle, so bytes that cause several events slow
// intake once the event queue fills.
// Reset: synchronous, active low aresetn; clears parser state, queue and
// output valid, and restores separator ',' and quote '"'.
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming csv tokenizer: front end parses bytes, a short queue decouples it
// from the back end that issues content, field-end and row-end events.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [csvft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data,
    // text input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] in_byte
    input  wire logic                            s_tlast,   // end_of_text
    // event output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] content_byte
    output logic [1:0]                           m_tuser,   // [1:0] event_kind
    output logic                                 m_tlast    // run_last
);
    import csvft_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    csv_bundle_t q_bundle;
    csv_qhead_t  qhead;

    // parser front end
    csvft_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_bundle  (q_bundle)
    );

    // event bundle queue
    csvft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_bundle (q_bundle),
        .full        (q_full),
        .pop         (q_pop),
        .qhead       (qhead)
    );

    // event issue back end
    csvft_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qhead    (qhead),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule : csv_field_tokenizer

`default_nettype wire

@@ hdl/csvft_front.sv @@
// ----------------------------------------------------------------------------
// csvft_front
// Accepts text bytes, holds the parser state and configuration, and turns
// each byte into a bundle of zero to three events for the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csvft_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [csvft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    // text input
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] in_byte
    input  wire logic                           s_tlast,   // end_of_text
    // event queue push side
    input  wire logic                           q_full,
    output logic                                q_push,
    output csvft_pkg::csv_bundle_t              q_bundle
);
    import csvft_pkg::*;

    logic [7:0] separator_reg;
    logic [7:0] quote_char_reg;
    logic       in_quotes_reg,  in_quotes_next;
    logic       esc_pend_reg,   esc_pend_next;
    logic       after_lb_reg,   after_lb_next;
    logic       fld_has_reg,    fld_has_next;
    logic       row_has_reg,    row_has_next;
    logic       accept;

    // append one event to a bundle, dropped once the bundle is full
    function automatic csv_bundle_t add_evt(csv_bundle_t b, logic [1:0] k, logic [7:0] d);
        csv_bundle_t r;
        r = b;
        if (b.cnt != 2'(MAX_EVTS)) begin
            r.evts[b.cnt] = '{kind: k, data: d};
            r.cnt         = b.cnt + 2'd1;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign q_push    = accept && (q_bundle.cnt != 2'd0);

    // classify the byte and work out its events and the next state
    always_comb begin
        csv_bundle_t bnd;
        logic        iq, ep, alb, fhc, rhf;
        bnd = '0;
        iq  = in_quotes_reg;
        ep  = esc_pend_reg;
        alb = after_lb_reg;
        fhc = fld_has_reg;
        rhf = row_has_reg;

        if (ep && s_tdata == quote_char_reg) begin
            // escaped quote gives a literal quote
            ep  = 1'b0;
            alb = 1'b0;
            fhc = 1'b1;
            bnd = add_evt(bnd, EV_CONTENT, quote_char_reg);
        end else begin
            // a held backslash that is not an escape is let go first
            if (ep) begin
                ep = 1'b0;
                if (quote_char_reg == CH_BACKSLASH) begin
                    iq = 1'b0;
                end else begin
                    bnd = add_evt(bnd, EV_CONTENT, CH_BACKSLASH);
                end
            end
            // ordinary byte handling
            if (s_tdata == CH_CR || s_tdata == CH_LF) begin
                if (!alb) begin
                    bnd = add_evt(bnd, EV_ROW, 8'h00);
                    fhc = 1'b0;
                    rhf = 1'b0;
                    alb = 1'b1;
                end
            end else begin
                alb = 1'b0;
                if (!iq) begin
                    if (s_tdata == separator_reg) begin
                        bnd = add_evt(bnd, EV_FIELD, 8'h00);
                        fhc = 1'b0;
                        rhf = 1'b1;
                    end else begin
                        fhc = 1'b1;
                        if (s_tdata == quote_char_reg) begin
                            iq = 1'b1;
                        end else begin
                            bnd = add_evt(bnd, EV_CONTENT, s_tdata);
                        end
                    end
                end else begin
                    fhc = 1'b1;
                    if (s_tdata == CH_BACKSLASH) begin
                        ep = 1'b1;
                    end else if (s_tdata == quote_char_reg) begin
                        iq = 1'b0;
                    end else begin
                        bnd = add_evt(bnd, EV_CONTENT, s_tdata);
                    end
                end
            end
        end

        // end of text closes whatever is open
        if (s_tlast) begin
            if (ep && quote_char_reg != CH_BACKSLASH) begin
                bnd = add_evt(bnd, EV_CONTENT, CH_BACKSLASH);
            end
            if (fhc || rhf) begin
                bnd = add_evt(bnd, EV_ROW, 8'h00);
            end
            iq  = 1'b0;
            ep  = 1'b0;
            alb = 1'b0;
            fhc = 1'b0;
            rhf = 1'b0;
        end

        q_bundle       = bnd;
        in_quotes_next = iq;
        esc_pend_next  = ep;
        after_lb_next  = alb;
        fld_has_next   = fhc;
        row_has_next   = rhf;
    end

    // parser state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg  <= SEP_RESET;
            quote_char_reg <= QUOTE_RESET;
            in_quotes_reg  <= 1'b0;
            esc_pend_reg   <= 1'b0;
            after_lb_reg   <= 1'b0;
            fld_has_reg    <= 1'b0;
            row_has_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SEPARATOR:  separator_reg  <= cfg_data;
                    CFG_QUOTE_CHAR: quote_char_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                in_quotes_reg <= in_quotes_next;
                esc_pend_reg  <= esc_pend_next;
                after_lb_reg  <= after_lb_next;
                fld_has_reg   <= fld_has_next;
                row_has_reg   <= row_has_next;
            end
        end
    end

`ifndef SYNTHESIS
    // the final byte of a text leaves the parser in its reset state
    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (!in_quotes_reg && !esc_pend_reg && !after_lb_reg
                                 && !fld_has_reg && !row_has_reg))
        else $error("parser state not cleared after end of text");
`endif

endmodule : csvft_front

`default_nettype wire

@@ hdl/csvft_queue.sv @@
// ----------------------------------------------------------------------------
// csvft_queue
// Short queue of event bundles between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module csvft_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire csvft_pkg::csv_bundle_t  push_bundle,
    output logic                         full,
    input  wire logic                    pop,
    output csvft_pkg::csv_qhead_t        qhead
);
    import csvft_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    csv_bundle_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign qhead.empty = (count_reg == '0);
    assign qhead.head  = mem[rd_ptr_reg];

    // pointer and fill count updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // bundle storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_bundle;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full event queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && qhead.empty))
        else $error("pop from empty event queue");

    a_no_empty_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_bundle.cnt != 2'd0))
        else $error("bundle without events pushed");
`endif

endmodule : csvft_queue

`default_nettype wire

@@ hdl/csvft_back.sv @@
// ----------------------------------------------------------------------------
// csvft_back
// Walks the events of the bundle at the queue head and presents them one at
// a time in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvft_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire csvft_pkg::csv_qhead_t qhead,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] content_byte
    output logic [1:0]                 m_tuser,   // [1:0] event_kind
    output logic                       m_tlast    // run_last
);
    import csvft_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg,  out_data_next;
    logic [1:0] out_kind_reg,  out_kind_next;
    logic       out_last_reg,  out_last_next;
    logic [1:0] slot_reg,      slot_next;
    logic       load;
    logic       last_slot;
    csv_evt_t   cur_evt;

    assign load      = !out_valid_reg || m_tready;
    assign cur_evt   = qhead.head.evts[slot_reg];
    assign last_slot = (slot_reg == qhead.head.cnt - 2'd1);
    assign q_pop     = load && !qhead.empty && last_slot;

    // next event into the output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        slot_next      = slot_reg;
        if (load) begin
            out_valid_next = !qhead.empty;
            if (!qhead.empty) begin
                out_data_next = cur_evt.data;
                out_kind_next = cur_evt.kind;
                out_last_next = last_slot;
                slot_next     = last_slot ? 2'd0 : slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            slot_reg      <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
        end
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // field and row ends carry no content byte
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_CONTENT) |-> (m_tdata == 8'h00))
        else $error("end marker with nonzero data");
`endif

endmodule : csvft_back

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for csv_field_tokenizer. Text bytes are streamed in from
// a pending queue and every event is checked against a tokenizer predictor
// kept in step with the accepted bytes and the register writes. Phases change
// separator, quote and the idling on both sides; one phase holds the output
// off long enough to back the block up.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import csvft_pkg::*;

    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;

    // one text byte waiting to be sent
    typedef struct packed {
        logic [7:0] chr;
        logic       eot;
    } text_byte_t;

    // one tokenizer event as seen on the output
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } token_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    text_byte_t  pending_text[$];
    token_t      expected_tokens[$];
    token_t      step_tokens[$];
    logic        byte_taken         = 1'b0;
    logic        holding            = 1'b0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatch_count     = 0;
    int unsigned quiet_cycles       = 0;
    event        hold_go;

    // predictor copy of registers and parser state
    logic [7:0] tok_separator;
    logic [7:0] tok_quote;
    logic       tok_in_quotes;
    logic       tok_escape;
    logic       tok_after_break;
    logic       tok_field_open;
    logic       tok_row_open;

    csv_field_tokenizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // tokenizer predictor
    // ------------------------------------------------------------------------

    function automatic void clear_parser();
        tok_in_quotes   = 1'b0;
        tok_escape      = 1'b0;
        tok_after_break = 1'b0;
        tok_field_open  = 1'b0;
        tok_row_open    = 1'b0;
    endfunction

    // at most MAX_EVTS events per byte
    function automatic void add_token(logic [1:0] kind, logic [7:0] data);
        token_t t;
        if (step_tokens.size() < MAX_EVTS) begin
            t.kind = kind;
            t.data = data;
            t.last = 1'b0;
            step_tokens = {step_tokens, t};
        end
    endfunction

    // a held backslash that turned out not to escape a quote
    function automatic void drop_backslash();
        tok_escape = 1'b0;
        if (tok_quote == CH_BACKSLASH)
            tok_in_quotes = 1'b0;
        else
            add_token(EV_CONTENT, CH_BACKSLASH);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        // line breaks close field and row, a run of them counts once
        if (b == CH_CR || b == CH_LF) begin
            if (!tok_after_break) begin
                add_token(EV_ROW, 8'h00);
                tok_field_open  = 1'b0;
                tok_row_open    = 1'b0;
                tok_after_break = 1'b1;
            end
            return;
        end
        tok_after_break = 1'b0;
        if (!tok_in_quotes) begin
            if (b == tok_separator) begin
                add_token(EV_FIELD, 8'h00);
                tok_field_open = 1'b0;
                tok_row_open   = 1'b1;
                return;
            end
            tok_field_open = 1'b1;
            if (b == tok_quote)
                tok_in_quotes = 1'b1;
            else
                add_token(EV_CONTENT, b);
            return;
        end
        // inside quotes: backslash is held, quote closes, rest is content
        tok_field_open = 1'b1;
        if (b == CH_BACKSLASH)
            tok_escape = 1'b1;
        else if (b == tok_quote)
            tok_in_quotes = 1'b0;
        else
            add_token(EV_CONTENT, b);
    endfunction

    function automatic void predict_tokens(logic [7:0] b, logic eot);
        step_tokens.delete();
        if (tok_escape && b == tok_quote) begin
            tok_escape      = 1'b0;
            tok_after_break = 1'b0;
            tok_field_open  = 1'b1;
            add_token(EV_CONTENT, tok_quote);
        end else begin
            if (tok_escape)
                drop_backslash();
            parse_byte(b);
        end
        // end of text flushes a held backslash and closes an open row
        if (eot) begin
            if (tok_escape)
                drop_backslash();
            if (tok_field_open || tok_row_open)
                add_token(EV_ROW, 8'h00);
            clear_parser();
        end
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens = {expected_tokens, step_tokens[i]};
    endfunction

    function automatic void note_mismatch(string what, token_t want, token_t seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: expected kind %0d data %02h last %0b, %s %0d data %02h last %0b",
                     $realtime, what, want.kind, want.data, want.last,
                     "got kind", seen.kind, seen.data, seen.last);
    endfunction

    // ------------------------------------------------------------------------
    // predictor update and output check
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        token_t seen;
        token_t want;
        byte_taken = aresetn && s_tvalid && s_tready;
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_SEPARATOR)
                tok_separator = cfg_data;
            else if (cfg_index == CFG_QUOTE_CHAR)
                tok_quote = cfg_data;
        end
        if (byte_taken)
            predict_tokens(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            seen.kind = m_tuser;
            seen.data = m_tdata;
            seen.last = m_tlast;
            if (expected_tokens.size() == 0) begin
                note_mismatch("unexpected event", '0, seen);
            end else begin
                want = expected_tokens.pop_front();
                if (seen !== want)
                    note_mismatch("event mismatch", want, seen);
            end
        end
    end

    // ------------------------------------------------------------------------
    // text driver: next byte once the current request is taken
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : text_driver
        text_byte_t item;
        if (!s_tvalid || byte_taken) begin
            if (aresetn && pending_text.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                item = pending_text.pop_front();
                s_tdata  <= item.chr;
                s_tlast  <= item.eot;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // event sink with random stalls and an optional long hold
    always @(negedge aclk) begin
        m_tready <= !holding && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    initial forever begin
        @(hold_go);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding = 1'b0;
    end

    // no transfer on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drained, plus room for a byte that causes no event
    task automatic wait_idle();
        while (pending_text.size() != 0 || s_tvalid || expected_tokens.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic void queue_byte(logic [7:0] chr, logic eot);
        text_byte_t item;
        item.chr = chr;
        item.eot = eot;
        pending_text = {pending_text, item};
    endfunction

    // weighted towards the characters the parser reacts to
    function automatic logic [7:0] pick_char(logic [7:0] sep, logic [7:0] quote);
        case ($urandom_range(0, 11))
            0, 1:    return sep;
            2, 3:    return quote;
            4:       return CH_BACKSLASH;
            5:       return CH_CR;
            6:       return CH_LF;
            7, 8, 9: return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_texts(logic [7:0] sep, logic [7:0] quote, int unsigned count);
        int unsigned len;
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            for (int unsigned k = 0; k < len; k++)
                queue_byte(pick_char(sep, quote), k == len - 1);
            sent += len;
        end
    endfunction

    task automatic run_phase(input logic [7:0] sep, input logic [7:0] quote,
                             input int unsigned idle_pct, input int unsigned stall_pct);
        wait_idle();
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_QUOTE_CHAR, quote);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    initial begin
        tok_separator = SEP_RESET;
        tok_quote     = QUOTE_RESET;
        clear_parser();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: escapes, literal separator, a CR LF break run
        queue_byte("a", 1'b0);
        queue_byte(",", 1'b0);
        queue_byte(QUOTE_RESET, 1'b0);
        queue_byte("b", 1'b0);
        queue_byte(",", 1'b0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte(QUOTE_RESET, 1'b0);
        queue_byte("c", 1'b0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte("d", 1'b0);
        queue_byte(QUOTE_RESET, 1'b0);
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_LF, 1'b0);
        queue_byte(",", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // line break in quotes, then a byte giving three events
        queue_byte(QUOTE_RESET, 1'b0);
        queue_byte(CH_LF, 1'b0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte(",", 1'b1);
        // backslash held at end of text
        queue_byte(QUOTE_RESET, 1'b0);
        queue_byte(CH_BACKSLASH, 1'b1);
        // empty row
        queue_byte(CH_LF, 1'b1);

        // extreme registers, full rate, output held off to back up the input
        run_phase(8'h00, 8'hFF, 0, 0);
        queue_texts(8'h00, 8'hFF, 12);
        -> hold_go;

        // backslash as quote, sender mostly idle
        run_phase(";", CH_BACKSLASH, 78, 0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte("x", 1'b0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte("y", 1'b1);
        queue_texts(";", CH_BACKSLASH, 12);

        // other extremes, receiver mostly stalling
        run_phase(8'hFF, 8'h00, 0, 78);
        queue_texts(8'hFF, 8'h00, 12);

        // both sides idling now and then
        run_phase("|", "'", 26, 26);
        queue_texts("|", "'", 12);

        // arbitrary registers
        begin : random_format
            logic [7:0] sep;
            logic [7:0] quote;
            sep   = 8'($urandom_range(0, 255));
            quote = 8'($urandom_range(0, 255));
            run_phase(sep, quote, 0, 0);
            queue_texts(sep, quote, 12);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
